// ----- rtl/core/trba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trba_pkg
// Types and codes shared by the thread region bump allocator and its engine.
// ----------------------------------------------------------------------------
package trba_pkg;

   // Request action codes
   localparam logic ACT_ALLOC  = 1'b0;
   localparam logic ACT_REINIT = 1'b1;

   // Fixed field widths of the transactions
   localparam int SIZE_W     = 16;
   localparam int TID_IN_W   = 8;
   localparam int ADDR_OUT_W = 18;
   localparam int IDX_OUT_W  = 6;
   localparam int COUNT_W    = 7;
   localparam int OBJ_W      = 16;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ZERO    = 2'd1,
      ST_TOO_BIG = 2'd2,
      ST_NONE    = 2'd3
   } trba_status_type;

   typedef struct packed {
      logic                action;
      logic [SIZE_W-1:0]   alloc_size;
      logic [TID_IN_W-1:0] thread_id;
   } trba_req_type;

   typedef struct packed {
      trba_status_type       status;
      logic [ADDR_OUT_W-1:0] heap_address;
      logic [IDX_OUT_W-1:0]  region_index;
   } trba_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CLAIM,
      S_PLACE,
      S_DONE
   } trba_state_type;

endpackage

// ----- rtl/core/trba_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trba_engine
// Region table memory and the sequencer that scans, claims and bumps regions.
// ----------------------------------------------------------------------------
module trba_engine #(
   parameter int MAX_REGIONS    = 64,
   parameter int REGION_BYTES   = 4096,
   parameter int THREAD_ID_BITS = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  trba_pkg::trba_req_type                      req,
   input  logic [$clog2(MAX_REGIONS+1)-1:0]            eff_count,
   output logic                                        idle,
   output logic                                        done,
   input  logic                                        take,
   output trba_pkg::trba_rsp_type                      rsp
);
   import trba_pkg::*;

   localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
   localparam int RIDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int FILL_W  = $clog2(REGION_BYTES + 1);
   localparam int TID_W   = THREAD_ID_BITS;
   localparam int ENTRY_W = TID_W + FILL_W + OBJ_W;
   localparam int SZ_W    = ((FILL_W > SIZE_W) ? FILL_W : SIZE_W) + 1;
   localparam int ADDR_W  = RIDX_W + FILL_W;

   trba_state_type state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [TID_W-1:0]  tid_ff, tid_in;
   logic [CNT_W-1:0]  lim_ff, lim_in;
   logic [CNT_W-1:0]  eff_ff, eff_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [RIDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]  fresh_ff, fresh_in;
   logic [RIDX_W-1:0] place_idx_ff, place_idx_in;
   logic [FILL_W-1:0] place_fill_ff, place_fill_in;
   logic [OBJ_W-1:0]  place_obj_ff, place_obj_in;
   trba_rsp_type      rsp_ff, rsp_in;

   logic [ENTRY_W-1:0] mem [MAX_REGIONS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [RIDX_W-1:0]  rd_addr;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;

   logic [TID_W+TID_IN_W-1:0] tid_ext;
   logic [TID_W-1:0]          rd_owner;
   logic [FILL_W-1:0]         rd_fill;
   logic [OBJ_W-1:0]          rd_obj;
   logic                      hit;
   logic [SZ_W-1:0]           room;
   logic [FILL_W-1:0]         new_fill;
   logic [OBJ_W-1:0]          new_obj;
   logic [ADDR_W-1:0]         addr_full;
   logic [ADDR_W+ADDR_OUT_W-1:0] addr_ext;
   logic [RIDX_W+IDX_OUT_W-1:0]  idx_ext;

   // Compare thread ids in their low THREAD_ID_BITS bits
   assign tid_ext = {{TID_W{1'b0}}, req.thread_id};

   // Unpack the entry read back from the table
   assign rd_owner = rd_data_ff[ENTRY_W-1 -: TID_W];
   assign rd_fill  = rd_data_ff[FILL_W+OBJ_W-1 -: FILL_W];
   assign rd_obj   = rd_data_ff[OBJ_W-1:0];
   assign room     = SZ_W'(REGION_BYTES) - SZ_W'(rd_fill);
   assign hit      = (rd_owner == tid_ff) && (SZ_W'(size_ff) <= room);

   // Bump update and placement address
   assign new_fill  = FILL_W'(SZ_W'(place_fill_ff) + SZ_W'(size_ff));
   assign new_obj   = (place_obj_ff == {OBJ_W{1'b1}}) ? place_obj_ff : place_obj_ff + 1'b1;
   assign addr_full = ADDR_W'(place_idx_ff) * ADDR_W'(REGION_BYTES) + ADDR_W'(place_fill_ff);
   assign addr_ext  = {{ADDR_OUT_W{1'b0}}, addr_full};
   assign idx_ext   = {{IDX_OUT_W{1'b0}}, place_idx_ff};
   assign wr_data   = {tid_ff, new_fill, new_obj};

   // Region table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[place_idx_ff] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fresh_ff     <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         chk_valid_ff <= chk_valid_in;
      end
      size_ff       <= size_in;
      tid_ff        <= tid_in;
      lim_ff        <= lim_in;
      eff_ff        <= eff_in;
      iss_ff        <= iss_in;
      chk_idx_ff    <= chk_idx_in;
      place_idx_ff  <= place_idx_in;
      place_fill_ff <= place_fill_in;
      place_obj_ff  <= place_obj_in;
      rsp_ff        <= rsp_in;
   end

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      tid_in        = tid_ff;
      lim_in        = lim_ff;
      eff_in        = eff_ff;
      iss_in        = iss_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      fresh_in      = fresh_ff;
      place_idx_in  = place_idx_ff;
      place_fill_in = place_fill_ff;
      place_obj_in  = place_obj_ff;
      rsp_in        = rsp_ff;
      rd_addr       = iss_ff[RIDX_W-1:0];
      wr_en         = 1'b0;
      idle          = 1'b0;
      done          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (start) begin
               size_in = req.alloc_size;
               tid_in  = tid_ext[TID_W-1:0];
               eff_in  = eff_count;
               // Only claimed regions below the count can hold a bump
               lim_in  = (fresh_ff < eff_count) ? fresh_ff : eff_count;
               iss_in  = '0;
               rsp_in  = '{status: ST_OK, heap_address: '0, region_index: '0};
               if (req.action == ACT_REINIT) begin
                  fresh_in = '0;
                  state_in = S_DONE;
               end else if (req.alloc_size == '0) begin
                  rsp_in.status = ST_ZERO;
                  state_in      = S_DONE;
               end else if (SZ_W'(req.alloc_size) > SZ_W'(REGION_BYTES)) begin
                  rsp_in.status = ST_TOO_BIG;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // Issue the next read while checking the one returned
            if (iss_ff < lim_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = iss_ff[RIDX_W-1:0];
               iss_in       = iss_ff + 1'b1;
            end
            if (chk_valid_ff && hit) begin
               chk_valid_in  = 1'b0;
               place_idx_in  = chk_idx_ff;
               place_fill_in = rd_fill;
               place_obj_in  = rd_obj;
               state_in      = S_PLACE;
            end else if (!chk_valid_ff && (iss_ff >= lim_ff)) begin
               state_in = S_CLAIM;
            end
         end

         S_CLAIM: begin
            if (fresh_ff < eff_ff) begin
               place_idx_in  = fresh_ff[RIDX_W-1:0];
               place_fill_in = '0;
               place_obj_in  = '0;
               fresh_in      = fresh_ff + 1'b1;
               state_in      = S_PLACE;
            end else begin
               rsp_in.status = ST_NONE;
               state_in      = S_DONE;
            end
         end

         S_PLACE: begin
            wr_en                = 1'b1;
            rsp_in.status        = ST_OK;
            rsp_in.heap_address  = addr_ext[ADDR_OUT_W-1:0];
            rsp_in.region_index  = idx_ext[IDX_OUT_W-1:0];
            state_in             = S_DONE;
         end

         S_DONE: begin
            done = 1'b1;
            if (take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp = rsp_ff;

endmodule

// ----- rtl/core/thread_region_bump_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_region_bump_allocator
// Thread-owned region bump allocator over a heap of fixed-size regions.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | trba_req_type
//  rsp_    | out       | rsp_valid/rsp_stall | trba_rsp_type
//  csr_    | in        | csr_valid/csr_ready | region_count, 7 bits
//
//  One request at a time. Reinitialize, zero size and oversize go from
//  idle straight to the done state, whose result then loads the output
//  register. An allocation scans the claimed regions below the count
//  through the region table read port, one entry a cycle, then claims a
//  fresh region if none has room, and writes the bumped entry back.
//  Reset is synchronous; it marks every region unclaimed and sets the count
//  to 64. Requests and count writes are held off while reset is high.
//  A stalled result sits in the output register while the next
//  request is taken.
// ----------------------------------------------------------------------------
module thread_region_bump_allocator #(
   parameter int MAX_REGIONS    = 64,
   parameter int REGION_BYTES   = 4096,
   parameter int THREAD_ID_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  trba_pkg::trba_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output trba_pkg::trba_rsp_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [trba_pkg::COUNT_W-1:0]        csr_data
);
   import trba_pkg::*;

   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int CMP_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

   logic [COUNT_W-1:0] region_count_ff;
   logic [CNT_W-1:0]   eff_count;
   logic               rsp_valid_ff;
   trba_rsp_type       rsp_data_ff;
   logic               eng_idle;
   logic               eng_done;
   logic               take;
   logic               start;
   trba_rsp_type       eng_rsp;

   // Region count register, ready whenever out of reset
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_count_ff <= COUNT_W'(64);
      end else if (csr_valid && csr_ready) begin
         region_count_ff <= csr_data;
      end
   end

   // Limit the count to the table depth
   assign eff_count = (CMP_W'(region_count_ff) > CMP_W'(MAX_REGIONS)) ?
                      CNT_W'(MAX_REGIONS) : CNT_W'(region_count_ff);

   // Accept a transaction while the engine is idle
   assign req_stall = !eng_idle || reset;
   assign start     = req_valid && !req_stall;

   // Load the output register when it is empty or being drained
   assign take = eng_done && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (take) begin
         rsp_data_ff <= eng_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   trba_engine #(
      .MAX_REGIONS    (MAX_REGIONS),
      .REGION_BYTES   (REGION_BYTES),
      .THREAD_ID_BITS (THREAD_ID_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .eff_count (eff_count),
      .idle      (eng_idle),
      .done      (eng_done),
      .take      (take),
      .rsp       (eng_rsp)
   );

endmodule
